/* design/dla_particle_walker_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the particle walker core
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DLA_PARTICLE_WALKER_CORE_MACROS_SVH
`define DLA_PARTICLE_WALKER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DLA_PW_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DLA_PW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dla_pw_pkg.sv */
// ----------------------------------------------------------------------------
// Particle walker package
// Grid geometry, codes, state type and the window bounds helper.
// ----------------------------------------------------------------------------
package dla_pw_pkg;

    // Grid geometry.
    localparam int COORD_W   = 10;
    localparam int GRID_SIZE = 2 ** COORD_W;
    localparam int CENTER    = GRID_SIZE / 2;

    // Occupancy memory organisation: one bit per cell, packed into words.
    localparam int WORD_W = 64;
    localparam int OFS_W  = $clog2(WORD_W);
    localparam int ADDR_W = 2 * COORD_W - OFS_W;
    localparam int DEPTH  = 2 ** ADDR_W;

    // Neighbour directions.
    localparam int NUM_DIRS    = 8;
    localparam int DIR_W       = $clog2(NUM_DIRS);
    localparam int PROBE_CNT_W = $clog2(NUM_DIRS + 1);

    localparam logic signed [1:0] DX_TAB [NUM_DIRS] =
        '{-2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1};
    localparam logic signed [1:0] DY_TAB [NUM_DIRS] =
        '{-2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd1};

    // Configuration registers.
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0]     CFG_RESET  = 11'd200;

    // Stream words.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic REQ_SPAWN = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    typedef enum logic [1:0] {
        ST_WALKING   = 2'd0,
        ST_STUCK     = 2'd1,
        ST_REJECTED  = 2'd2,
        ST_NO_WALKER = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SPAWN_CHK,
        S_PROBE,
        S_SET_RD,
        S_SET_WR,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
    } t_bounds;

    // Bounds of the active window along one axis for a configured size.
    function automatic t_bounds win_bounds(logic [CFG_W-1:0] w);
        logic [CFG_W-1:0]          wc;
        logic signed [CFG_W+1:0]   lo;
        logic signed [CFG_W+1:0]   hi;
        logic signed [CFG_W+1:0]   top;
        t_bounds                   b;
        wc = w;
        if (wc == '0) wc = CFG_W'(1);
        if (wc > CFG_W'(GRID_SIZE)) wc = CFG_W'(GRID_SIZE);
        top = signed'((CFG_W + 2)'(GRID_SIZE - 1));
        lo  = signed'((CFG_W + 2)'(CENTER)) - signed'({2'b00, wc >> 1});
        hi  = signed'((CFG_W + 2)'(CENTER)) + signed'({2'b00, (wc - CFG_W'(1)) >> 1});
        if (lo < 0) lo = '0;
        if (lo > top) lo = top;
        if (hi > top) hi = top;
        b.lo = lo[COORD_W-1:0];
        b.hi = hi[COORD_W-1:0];
        return b;
    endfunction

endpackage

/* design/dla_particle_walker_core.sv */
// Sequence: a step without a walker goes from acceptance straight to its result; a spawn
// first checks its own cell, and a rejected one then reports. A walking step or spawn
// probes the eight neighbours one per cycle over the single memory read port, then a hit
// rewrites the walker's word; no new word is taken before the last result is registered.
// Reset: synchronous, active low; afterwards a clearing pass sweeps the 16384-word
// occupancy memory, one 64-bit word a cycle, and no input word is taken meanwhile.
// ----------------------------------------------------------------------------
// Particle walker core
// Diffusion-limited aggregation on a 1024 x 1024 bit grid with a sequenced
// neighbour probe over one shared move unit and one occupancy memory.
// ----------------------------------------------------------------------------
`include "dla_particle_walker_core_macros.svh"

module dla_particle_walker_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input stream.
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // tdata, from bit 0: spawn_x[9:0], spawn_y[9:0], direction[2:0], zero pad.
    input  logic [dla_pw_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // tuser, from bit 0: req_type.
    input  logic                                  i_s_tuser,
    // Output stream.
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // tdata, from bit 0: status[1:0], walker_x[9:0], walker_y[9:0], zero pad.
    output logic [dla_pw_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // Configuration write channel.
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [dla_pw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dla_pw_pkg::CFG_W-1:0]          i_cfg_data
);
    import dla_pw_pkg::*;

    // The centre cell is the only one set once the clearing pass has finished.
    localparam int                CENTER_IDX  = CENTER * GRID_SIZE + CENTER;
    localparam logic [ADDR_W-1:0] CENTER_WORD = ADDR_W'(CENTER_IDX / WORD_W);
    localparam logic [WORD_W-1:0] CENTER_MASK = WORD_W'(1) << (CENTER_IDX % WORD_W);

    // The occupancy memory holds the row in the upper address bits and the
    // upper column bits below them; the low column bits select the bit.
    function automatic logic [ADDR_W-1:0] word_of(logic [COORD_W-1:0] x,
                                                  logic [COORD_W-1:0] y);
        logic [2*COORD_W-1:0] idx;
        idx = {y, x};
        return idx[2*COORD_W-1:OFS_W];
    endfunction

    function automatic logic [OFS_W-1:0] bit_of(logic [COORD_W-1:0] x);
        return x[OFS_W-1:0];
    endfunction

    // Control and walker state.
    t_state                  r_state, n_state;
    logic [PROBE_CNT_W-1:0]  r_k, n_k;
    logic [ADDR_W-1:0]       r_clr, n_clr;
    logic                    r_active, n_active;
    logic [COORD_W-1:0]      r_pos_x, n_pos_x;
    logic [COORD_W-1:0]      r_pos_y, n_pos_y;
    logic [COORD_W-1:0]      r_sx, n_sx;
    logic [COORD_W-1:0]      r_sy, n_sy;
    logic                    r_in_win, n_in_win;
    t_status                 r_status, n_status;
    logic                    r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_data, n_out_data;
    t_bounds                 r_bnd_x, r_bnd_y;

    // Memory side.
    logic [WORD_W-1:0]       mem [DEPTH];
    logic [WORD_W-1:0]       r_rdata;
    logic [OFS_W-1:0]        r_rbit, n_rbit;
    logic [ADDR_W-1:0]       mem_raddr;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [WORD_W-1:0]       mem_wdata;
    logic                    mem_we;
    logic [COORD_W-1:0]      rd_x, rd_y;

    // Shared move unit.
    logic [DIR_W-1:0]        wrap_dir;
    logic [COORD_W-1:0]      wrap_x, wrap_y;

    // Input word fields.
    logic [COORD_W-1:0]      in_x, in_y;
    logic [DIR_W-1:0]        in_dir;
    logic                    in_win;

    assign in_x   = i_s_tdata[COORD_W-1:0];
    assign in_y   = i_s_tdata[2*COORD_W-1:COORD_W];
    assign in_dir = i_s_tdata[2*COORD_W+DIR_W-1:2*COORD_W];
    assign in_win = (in_x >= r_bnd_x.lo) && (in_x <= r_bnd_x.hi) &&
                    (in_y >= r_bnd_y.lo) && (in_y <= r_bnd_y.hi);

    // The same move unit serves the step move on acceptance and every
    // neighbour probe afterwards; the probe counter picks the direction.
    dla_pw_wrap u_wrap (
        .i_pos_x (r_pos_x),
        .i_pos_y (r_pos_y),
        .i_dir   (wrap_dir),
        .i_bnd_x (r_bnd_x),
        .i_bnd_y (r_bnd_y),
        .o_x     (wrap_x),
        .o_y     (wrap_y)
    );

    // Window bounds are worked out as the register is written, so a word
    // accepted in the very next cycle already sees the new window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bnd_x <= win_bounds(CFG_RESET);
            r_bnd_y <= win_bounds(CFG_RESET);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_bnd_x <= win_bounds(i_cfg_data);
                CFG_HEIGHT: r_bnd_y <= win_bounds(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Occupancy memory: one write and one registered read each cycle. The
    // read bit offset travels alongside so that it lines up with the data.
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rdata <= mem[mem_raddr];
        r_rbit  <= n_rbit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_k         <= '0;
            r_clr       <= '0;
            r_active    <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_status    <= ST_WALKING;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_clr       <= n_clr;
            r_active    <= n_active;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_sx       <= n_sx;
        r_sy       <= n_sy;
        r_in_win   <= n_in_win;
        r_out_data <= n_out_data;
    end

    // Sequencer. A spawn reads its own cell on acceptance and decides in the
    // next cycle. The probe state issues one neighbour read per cycle and
    // tests the data of the previous read, and the first occupied neighbour
    // ends the search. Sticking is a read-modify-write of the walker's own word.
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_clr       = r_clr;
        n_active    = r_active;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_in_win    = r_in_win;
        n_status    = r_status;
        n_out_valid = r_out_valid & ~i_m_tready;
        n_out_data  = r_out_data;
        o_s_tready  = 1'b0;
        wrap_dir    = r_k[DIR_W-1:0];
        rd_x        = r_pos_x;
        rd_y        = r_pos_y;
        mem_we      = 1'b0;
        mem_waddr   = word_of(r_pos_x, r_pos_y);
        mem_wdata   = r_rdata | (WORD_W'(1) << r_rbit);

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = (r_clr == CENTER_WORD) ? CENTER_MASK : '0;
                n_clr     = r_clr + ADDR_W'(1);
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                wrap_dir   = in_dir;
                rd_x       = in_x;
                rd_y       = in_y;
                if (i_s_tvalid) begin
                    if (i_s_tuser == REQ_SPAWN) begin
                        n_sx     = in_x;
                        n_sy     = in_y;
                        n_in_win = in_win;
                        n_state  = S_SPAWN_CHK;
                    end else if (!r_active) begin
                        n_status = ST_NO_WALKER;
                        n_state  = S_RESULT;
                    end else begin
                        n_pos_x = wrap_x;
                        n_pos_y = wrap_y;
                        n_k     = '0;
                        n_state = S_PROBE;
                    end
                end
            end
            S_SPAWN_CHK: begin
                if (!r_in_win || r_rdata[r_rbit]) begin
                    n_status = ST_REJECTED;
                    n_state  = S_RESULT;
                end else begin
                    n_pos_x  = r_sx;
                    n_pos_y  = r_sy;
                    n_active = 1'b1;
                    n_k      = '0;
                    n_state  = S_PROBE;
                end
            end
            S_PROBE: begin
                rd_x = wrap_x;
                rd_y = wrap_y;
                if ((r_k != '0) && r_rdata[r_rbit]) begin
                    n_state = S_SET_RD;
                end else if (r_k == PROBE_CNT_W'(NUM_DIRS)) begin
                    n_status = ST_WALKING;
                    n_state  = S_RESULT;
                end else begin
                    n_k = r_k + PROBE_CNT_W'(1);
                end
            end
            S_SET_RD: begin
                n_state = S_SET_WR;
            end
            S_SET_WR: begin
                mem_we   = 1'b1;
                n_active = 1'b0;
                n_status = ST_STUCK;
                n_state  = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_TDATA_W'({r_pos_y, r_pos_x, r_status});
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        mem_raddr = word_of(rd_x, rd_y);
        n_rbit    = bit_of(rd_x);
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // A step without a walker goes straight to its result.
    `DLA_PW_ASSERT_NEXT(a_step_no_walker,
        i_s_tvalid && o_s_tready && (i_s_tuser == REQ_STEP) && !r_active,
        (r_state == S_RESULT) && (r_status == ST_NO_WALKER),
        "step without walker did not report so")
    // Neighbours are only probed around a live walker.
    `DLA_PW_ASSERT_SAME(a_probe_active, r_state == S_PROBE, r_active,
        "neighbour probe without an active walker")
    // The probe counter never runs past the number of directions.
    `DLA_PW_ASSERT_SAME(a_probe_count, r_state == S_PROBE,
        r_k <= PROBE_CNT_W'(NUM_DIRS), "probe counter out of range")
    // Setting the cell ends the walker and reports it stuck.
    `DLA_PW_ASSERT_NEXT(a_stick_ends, r_state == S_SET_WR,
        !r_active && (r_status == ST_STUCK) && (r_state == S_RESULT),
        "stuck walker not retired")

endmodule

/* design/dla_pw_wrap.sv */
// ----------------------------------------------------------------------------
// Particle walker move unit
// Moves a position one cell in a direction, wrapping at the window edges.
// ----------------------------------------------------------------------------
module dla_pw_wrap (
    input  logic [dla_pw_pkg::COORD_W-1:0] i_pos_x,
    input  logic [dla_pw_pkg::COORD_W-1:0] i_pos_y,
    input  logic [dla_pw_pkg::DIR_W-1:0]   i_dir,
    input  dla_pw_pkg::t_bounds            i_bnd_x,
    input  dla_pw_pkg::t_bounds            i_bnd_y,
    output logic [dla_pw_pkg::COORD_W-1:0] o_x,
    output logic [dla_pw_pkg::COORD_W-1:0] o_y
);
    import dla_pw_pkg::*;

    // A move past the high bound lands on the low bound and vice versa.
    function automatic logic [COORD_W-1:0] wrap1(logic [COORD_W-1:0] p,
                                                 logic signed [1:0] d,
                                                 t_bounds b);
        logic signed [COORD_W+1:0] n;
        logic signed [COORD_W+1:0] lo;
        logic signed [COORD_W+1:0] hi;
        lo = signed'({2'b00, b.lo});
        hi = signed'({2'b00, b.hi});
        n  = signed'({2'b00, p}) + signed'({{COORD_W{d[1]}}, d});
        if (n > hi) n = lo;
        if (n < lo) n = hi;
        return n[COORD_W-1:0];
    endfunction

    assign o_x = wrap1(i_pos_x, DX_TAB[i_dir], i_bnd_x);
    assign o_y = wrap1(i_pos_y, DY_TAB[i_dir], i_bnd_y);

endmodule

/* tb/sv/tb_dla_particle_walker_core.sv */
// ----------------------------------------------------------------------------
// Particle walker core testbench
// Drives spawn and step words into the walker, keeps its own model of the
// occupancy grid, the walker and the window registers, and checks every
// result word field by field against the predicted walk.
// ----------------------------------------------------------------------------
module tb_dla_particle_walker_core;

    import dla_pw_pkg::*;

    // Run controls.
    localparam int WATCHDOG_CYCLES = 800000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int IDLE_PERCENT    = 29;
    localparam int SHOWN_FAULTS    = 10;

    // A register index that the block has no register behind.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Step offsets per direction, columns and rows.
    localparam int STEP_DX [NUM_DIRS] = '{-1, -1, -1, 0, 0, 1, 1, 1};
    localparam int STEP_DY [NUM_DIRS] = '{-1, 0, 1, -1, 1, -1, 0, 1};

    typedef struct {
        t_status            status;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } walk_result_t;

    // Block ports.
    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic                   i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;

    // Predicted state of the block.
    bit               occupied [int];
    int unsigned      stuck_cells [$];
    int               walk_x;
    int               walk_y;
    bit               walker_live;
    logic [CFG_W-1:0] win_w;
    logic [CFG_W-1:0] win_h;

    // Results still owed by the block, oldest first.
    walk_result_t expected_walks [$];

    // Bookkeeping.
    bit calm_mode;
    int fault_cnt;
    int cycle_count;
    int settings_seen;
    int status_tally [4];

    dla_particle_walker_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Walk predictor
    // ------------------------------------------------------------------------

    // Low and high bound of the window along one axis. Sizes of zero count as
    // one, sizes beyond the grid as the whole grid.
    function automatic void axis_window(input logic [CFG_W-1:0] size,
                                        output int lo, output int hi);
        int s;
        s = int'(size);
        if (s < 1) s = 1;
        if (s > GRID_SIZE) s = GRID_SIZE;
        lo = CENTER - s / 2;
        hi = CENTER + (s - 1) / 2;
        if (lo < 0) lo = 0;
        if (lo > GRID_SIZE - 1) lo = GRID_SIZE - 1;
        if (hi > GRID_SIZE - 1) hi = GRID_SIZE - 1;
    endfunction

    // One move along an axis. Leaving above the high bound lands on the low
    // bound and the other way round, which also pulls a walker that a window
    // change left outside back into the window.
    function automatic int wrap_move(input int p, input int d, input int lo, input int hi);
        int n;
        n = p + d;
        if (n > hi) n = lo;
        if (n < lo) n = hi;
        return n;
    endfunction

    function automatic bit cell_taken(input int x, input int y);
        return occupied.exists(y * GRID_SIZE + x);
    endfunction

    function automatic void mark_cell(input int x, input int y);
        occupied[y * GRID_SIZE + x] = 1'b1;
        stuck_cells.push_back(y * GRID_SIZE + x);
    endfunction

    // True when any of the eight wrapped neighbours of the walker is set. In
    // a narrow window a neighbour may be the walker's own cell.
    function automatic bit touches_cluster(input int xlo, input int xhi,
                                           input int ylo, input int yhi);
        for (int k = 0; k < NUM_DIRS; k++) begin
            if (cell_taken(wrap_move(walk_x, STEP_DX[k], xlo, xhi),
                           wrap_move(walk_y, STEP_DY[k], ylo, yhi)))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void reset_predictor();
        occupied.delete();
        stuck_cells.delete();
        mark_cell(CENTER, CENTER);
        walk_x      = 0;
        walk_y      = 0;
        walker_live = 1'b0;
        win_w       = CFG_RESET;
        win_h       = CFG_RESET;
    endfunction

    function automatic walk_result_t predict_walk(input logic rt,
                                                  input logic [COORD_W-1:0] sx,
                                                  input logic [COORD_W-1:0] sy,
                                                  input logic [DIR_W-1:0] dir);
        int           xlo, xhi, ylo, yhi;
        int           ix, iy;
        walk_result_t res;
        axis_window(win_w, xlo, xhi);
        axis_window(win_h, ylo, yhi);
        ix = int'(sx);
        iy = int'(sy);
        res.status = ST_WALKING;
        if (rt == REQ_SPAWN) begin
            // A spawn outside the window or on a set cell leaves the walker alone.
            if (ix < xlo || ix > xhi || iy < ylo || iy > yhi || cell_taken(ix, iy)) begin
                res.status = ST_REJECTED;
            end else begin
                walk_x      = ix;
                walk_y      = iy;
                walker_live = 1'b1;
            end
        end else if (!walker_live) begin
            res.status = ST_NO_WALKER;
        end else begin
            walk_x = wrap_move(walk_x, STEP_DX[dir], xlo, xhi);
            walk_y = wrap_move(walk_y, STEP_DY[dir], ylo, yhi);
        end
        if (res.status == ST_WALKING && touches_cluster(xlo, xhi, ylo, yhi)) begin
            mark_cell(walk_x, walk_y);
            walker_live = 1'b0;
            res.status  = ST_STUCK;
        end
        res.x = walk_x[COORD_W-1:0];
        res.y = walk_y[COORD_W-1:0];
        status_tally[int'(res.status)]++;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: the receiver stalls at random, except in calm stretches,
    // and every accepted result word is compared with the oldest prediction.
    // ------------------------------------------------------------------------

    always @(negedge i_clk) begin
        i_m_tready <= calm_mode || ($urandom_range(99) >= IDLE_PERCENT);
    end

    function automatic void note_fault(input string what);
        fault_cnt++;
        if (fault_cnt <= SHOWN_FAULTS) $display("fault %0d: %s", fault_cnt, what);
    endfunction

    always @(posedge i_clk) begin : check_results
        walk_result_t       want;
        logic [1:0]         got_status;
        logic [COORD_W-1:0] got_x;
        logic [COORD_W-1:0] got_y;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_status = o_m_tdata[1:0];
            got_x      = o_m_tdata[2 +: COORD_W];
            got_y      = o_m_tdata[2 + COORD_W +: COORD_W];
            if (expected_walks.size() == 0) begin
                note_fault($sformatf("unexpected result status %0d x %0d y %0d",
                                     got_status, got_x, got_y));
            end else begin
                want = expected_walks.pop_front();
                if (got_status !== want.status || got_x !== want.x || got_y !== want.y)
                    note_fault($sformatf("expected status %0d x %0d y %0d, got %0d x %0d y %0d",
                                         want.status, want.x, want.y,
                                         got_status, got_x, got_y));
            end
        end
    end

    // The watchdog allows for the clearing pass after reset and for every word
    // waiting out long stalls on both sides, several times over.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > WATCHDOG_CYCLES) begin
            $display("watchdog expired after %0d cycles, %0d results outstanding",
                     cycle_count, expected_walks.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request side. Each task starts and ends at a falling edge; a valid that
    // stays high for the next word is never lowered in between.
    // ------------------------------------------------------------------------

    task automatic send_walk_req(input logic rt, input logic [COORD_W-1:0] sx,
                                 input logic [COORD_W-1:0] sy, input logic [DIR_W-1:0] dir);
        walk_result_t res;
        while (!calm_mode && $urandom_range(99) < IDLE_PERCENT) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        res = predict_walk(rt, sx, sy, dir);
        expected_walks.push_back(res);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, dir, sy, sx};
        i_s_tuser  <= rt;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic spawn_at(input int x, input int y);
        send_walk_req(REQ_SPAWN, COORD_W'(x), COORD_W'(y), DIR_W'($urandom));
    endtask

    task automatic step_to(input int dir);
        send_walk_req(REQ_STEP, COORD_W'($urandom), COORD_W'($urandom), DIR_W'(dir));
    endtask

    // Stop sending and hold off until every owed result has arrived, then let
    // the block's pipeline run empty.
    task automatic wait_walks_settled();
        i_s_tvalid <= 1'b0;
        while (expected_walks.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Register writes only happen with the block idle.
    task automatic write_window_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
        wait_walks_settled();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_WIDTH) win_w = val;
        else if (idx == CFG_HEIGHT) win_h = val;
        settings_seen++;
    endtask

    task automatic set_window(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_window_reg(CFG_WIDTH, w);
        write_window_reg(CFG_HEIGHT, h);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Straight after reset there is no walker and only the centre is set.
    task automatic test_after_reset();
        step_to(5);
        spawn_at(CENTER, CENTER);
    endtask

    // Spawns one cell outside each edge of the default window, at the grid
    // corners, and on two window corners, the second replacing the first.
    task automatic test_spawn_window();
        int lo, hi;
        axis_window(win_w, lo, hi);
        spawn_at(lo - 1, CENTER - 12);
        spawn_at(hi + 1, CENTER - 12);
        spawn_at(CENTER - 12, lo - 1);
        spawn_at(CENTER - 12, hi + 1);
        spawn_at(0, 0);
        spawn_at(GRID_SIZE - 1, GRID_SIZE - 1);
        spawn_at(lo, lo);
        spawn_at(hi, hi);
    endtask

    // Wrap over the high corner, every direction once, then a walker that
    // sticks to the centre straight away and a step with nobody left to move.
    task automatic test_step_moves();
        step_to(7);
        for (int d = 0; d < NUM_DIRS; d++) step_to(d);
        spawn_at(CENTER + 1, CENTER + 1);
        step_to(2);
    endtask

    // Degenerate and oversized windows, a walker stranded outside the window
    // by a register change, and a write to an index with no register.
    task automatic test_window_limits();
        set_window(CFG_W'(0), CFG_W'(2047));
        spawn_at(CENTER, 0);
        step_to(3);
        set_window(CFG_W'(1025), CFG_W'(GRID_SIZE));
        spawn_at(100, 100);
        set_window(CFG_RESET, CFG_RESET);
        step_to(4);
        write_window_reg(CFG_SPARE, CFG_W'(7));
        step_to(0);
    endtask

    // Random phase under one window setting. Most traffic is a spawn close to
    // the cluster or inside the window followed by a short walk; the rest is
    // spawns anywhere on the grid and stray steps.
    task automatic run_walk_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                  input int n_req, input bit calm);
        int          sent, xlo, xhi, ylo, yhi, tx, ty, pick, n_steps;
        int unsigned seed_spot;
        set_window(w, h);
        calm_mode = calm;
        axis_window(w, xlo, xhi);
        axis_window(h, ylo, yhi);
        sent = 0;
        while (sent < n_req) begin
            pick = $urandom_range(99);
            if (pick < 2) wait_walks_settled();
            if (pick < 10) begin
                send_walk_req(REQ_SPAWN, COORD_W'($urandom), COORD_W'($urandom),
                              DIR_W'($urandom));
                sent++;
            end else if (pick < 15) begin
                step_to($urandom_range(NUM_DIRS - 1));
                sent++;
            end else begin
                if ($urandom_range(1) == 0) begin
                    seed_spot = stuck_cells[$urandom_range(stuck_cells.size() - 1)];
                    tx = int'(seed_spot % GRID_SIZE) + int'($urandom_range(6)) - 3;
                    ty = int'(seed_spot / GRID_SIZE) + int'($urandom_range(6)) - 3;
                end else begin
                    tx = int'($urandom_range(xhi, xlo));
                    ty = int'($urandom_range(yhi, ylo));
                end
                if (tx < 0) tx = 0;
                if (tx > GRID_SIZE - 1) tx = GRID_SIZE - 1;
                if (ty < 0) ty = 0;
                if (ty > GRID_SIZE - 1) ty = GRID_SIZE - 1;
                spawn_at(tx, ty);
                sent++;
                n_steps = $urandom_range(8, 1);
                for (int s = 0; s < n_steps; s++) step_to($urandom_range(NUM_DIRS - 1));
                sent += n_steps;
            end
        end
        calm_mode = 1'b0;
    endtask

    task automatic test_random_walks();
        run_walk_phase(CFG_W'(9), CFG_W'(9), 300, 1'b0);
        run_walk_phase(CFG_W'(24), CFG_W'(16), 300, 1'b0);
        // Long stretch with neither side idling.
        run_walk_phase(CFG_W'(GRID_SIZE), CFG_W'(GRID_SIZE), 250, 1'b1);
        run_walk_phase(CFG_W'(1), CFG_W'(64), 100, 1'b0);
        run_walk_phase(CFG_W'(2047), CFG_W'(0), 100, 1'b0);
        run_walk_phase(CFG_RESET, CFG_RESET, 350, 1'b0);
        run_walk_phase(CFG_W'(2), CFG_W'(3), 100, 1'b0);
        run_walk_phase(CFG_W'($urandom_range(63)), CFG_W'($urandom_range(63)), 200, 1'b0);
        run_walk_phase(CFG_W'($urandom_range(2047)), CFG_W'($urandom_range(2047)), 200, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = REQ_SPAWN;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_WIDTH;
        i_cfg_data  = '0;
        calm_mode   = 1'b0;
        fault_cnt   = 0;
        cycle_count = 0;
        settings_seen = 0;
        status_tally  = '{0, 0, 0, 0};
        reset_predictor();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_spawn_window();
        test_step_moves();
        test_window_limits();
        test_random_walks();
        wait_walks_settled();

        $display("Run covered %0d walking, %0d stuck, %0d rejected and %0d walkerless results",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
        $display("over %0d register writes; cluster holds %0d cells.",
                 settings_seen, stuck_cells.size());
        if (fault_cnt == 0 && expected_walks.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/dla_pw_pkg.sv
design/dla_pw_wrap.sv
design/dla_particle_walker_core.sv
tb/sv/tb_dla_particle_walker_core.sv
